// ===== hdl/vertex_triple_dedup_indexer_top_defines.svh =====
// Assertion macros for the vertex triple dedup indexer.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef VERTEX_TRIPLE_DEDUP_INDEXER_TOP_DEFINES_SVH
`define VERTEX_TRIPLE_DEDUP_INDEXER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VTDI_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vtdi check failed");
`define VTDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vtdi check failed");
`else
`define VTDI_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define VTDI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/vtdi_pkg.sv =====
// Shared types and constants of the vertex triple dedup indexer.
// No dependencies.
package vtdi_pkg;

   localparam int FIELD_BITS     = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int OUT_INDEX_BITS = 10;
   localparam int STATUS_BITS    = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_VERTEX_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEXCOORD_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NORMAL_COUNT   = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_VERTEX = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_TEX    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NORM   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL   = 3'd4;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pos_index;
      logic [FIELD_BITS-1:0] tex_index;
      logic [FIELD_BITS-1:0] norm_index;
   } req_type;

   typedef struct packed {
      logic [OUT_INDEX_BITS-1:0] out_index;
      logic                      is_new;
      logic [STATUS_BITS-1:0]    status;
   } rsp_type;

endpackage

// ===== hdl/vtdi_check.sv =====
// Index range check and key formation for one corner word.
// Depends on vtdi_pkg.
module vtdi_check
   import vtdi_pkg::*;
#(
   parameter int KEY_FIELD_BITS = 16
) (
   input  req_type                         req_word,
   input  logic [FIELD_BITS-1:0]           vertex_count,
   input  logic [FIELD_BITS-1:0]           texcoord_count,
   input  logic [FIELD_BITS-1:0]           normal_count,
   output logic [3*KEY_FIELD_BITS-1:0]     key,
   output logic [STATUS_BITS-1:0]          status
);

   localparam logic [FIELD_BITS-1:0] FIELD_MASK =
      FIELD_BITS'((33'd1 << KEY_FIELD_BITS) - 33'd1);

   logic [FIELD_BITS-1:0] pos_m;
   logic [FIELD_BITS-1:0] tex_m;
   logic [FIELD_BITS-1:0] norm_m;

   assign pos_m  = req_word.pos_index & FIELD_MASK;
   assign tex_m  = req_word.tex_index & FIELD_MASK;
   assign norm_m = req_word.norm_index & FIELD_MASK;

   assign key = {norm_m[KEY_FIELD_BITS-1:0], tex_m[KEY_FIELD_BITS-1:0],
                 pos_m[KEY_FIELD_BITS-1:0]};

   always_comb begin
      if (pos_m == '0 || pos_m > vertex_count) begin
         status = ST_VERTEX;
      end else if (tex_m > texcoord_count) begin
         status = ST_TEX;
      end else if (norm_m > normal_count) begin
         status = ST_NORM;
      end else begin
         status = ST_OK;
      end
   end

endmodule

// ===== hdl/vtdi_table.sv =====
// Hash slot memory with registered read and a clearing sweep after reset.
// Depends on vtdi_pkg.
module vtdi_table
   import vtdi_pkg::*;
#(
   parameter int SLOTS      = 2048,
   parameter int ENTRY_BITS = 59
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(SLOTS)-1:0]     wr_addr,
   input  logic [ENTRY_BITS-1:0]        wr_data,
   input  logic [$clog2(SLOTS)-1:0]     rd_addr,
   output logic [ENTRY_BITS-1:0]        rd_data,
   output logic                         ready
);

   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

   logic [ENTRY_BITS-1:0] mem [SLOTS];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic                  clearing_ff;
   logic                  clearing_in;
   logic [SLOT_BITS-1:0]  clr_addr_ff;
   logic [SLOT_BITS-1:0]  clr_addr_in;
   logic                  mem_we;
   logic [SLOT_BITS-1:0]  mem_waddr;
   logic [ENTRY_BITS-1:0] mem_wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_SLOT) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign mem_we    = clearing_ff | wr_en;
   assign mem_waddr = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clearing_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign ready   = ~clearing_ff;

endmodule

// ===== hdl/vertex_triple_dedup_indexer_top.sv =====
// Vertex triple dedup indexer: hashed slot table, linear probing, dense ids.
// Depends on vtdi_pkg, vtdi_check, vtdi_table and the defines header.
// A range error answers in the cycle after start is accepted; a lookup answers once a probed
// slot matches or is empty (one slot read per cycle through the table's read port).
// A lookup holds busy high while it probes, so the next word waits for its answer; rsp_strobe cannot be stalled.
// Reset: counts and next id clear; the table then clears all 2*TABLE_ENTRIES slots with busy high.
`include "vertex_triple_dedup_indexer_top_defines.svh"
module vertex_triple_dedup_indexer_top
   import vtdi_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024,
   parameter int INDEX_BITS    = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_word,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_word,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int KEY_FIELD_BITS = (INDEX_BITS < FIELD_BITS) ? INDEX_BITS : FIELD_BITS;
   localparam int KEY_BITS       = 3 * KEY_FIELD_BITS;
   localparam int ID_BITS        = $clog2(TABLE_ENTRIES);
   localparam int NEXT_BITS      = $clog2(TABLE_ENTRIES + 1);
   localparam int SLOTS          = 2 * TABLE_ENTRIES;
   localparam int SLOT_BITS      = $clog2(SLOTS);
   localparam int ENTRY_BITS     = 1 + ID_BITS + KEY_BITS;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);
   localparam logic [SLOT_BITS:0]   SLOTS_W   = (SLOT_BITS + 1)'(SLOTS);
   localparam logic [NEXT_BITS-1:0] FULL_ID   = NEXT_BITS'(TABLE_ENTRIES);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_PROBE = 1'b1;

   logic                      state_ff, state_in;
   logic [FIELD_BITS-1:0]     vertex_count_ff;
   logic [FIELD_BITS-1:0]     texcoord_count_ff;
   logic [FIELD_BITS-1:0]     normal_count_ff;
   logic [NEXT_BITS-1:0]      next_id_ff, next_id_in;
   logic [KEY_BITS-1:0]       key_ff, key_in;
   logic [SLOT_BITS-1:0]      probe_addr_ff, probe_addr_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [KEY_BITS-1:0]       chk_key;
   logic [STATUS_BITS-1:0]    chk_status;
   logic [SLOT_BITS-1:0]      hash_fold;
   logic [SLOT_BITS:0]        hash_sub;
   logic [SLOT_BITS-1:0]      hash_slot;
   logic [SLOT_BITS-1:0]      probe_next;
   logic                      accept;

   logic                      tbl_wr_en;
   logic [ENTRY_BITS-1:0]     tbl_wr_data;
   logic [SLOT_BITS-1:0]      tbl_rd_addr;
   logic [ENTRY_BITS-1:0]     tbl_rd_data;
   logic                      tbl_ready;

   logic                      ent_valid;
   logic [ID_BITS-1:0]        ent_id;
   logic [KEY_BITS-1:0]       ent_key;
   logic [ID_BITS-1:0]        new_id;
   logic [OUT_INDEX_BITS+ID_BITS-1:0] hit_wide;
   logic [OUT_INDEX_BITS+ID_BITS-1:0] new_wide;

   vtdi_check #(
      .KEY_FIELD_BITS(KEY_FIELD_BITS)
   ) u_check (
      .req_word       (req_word),
      .vertex_count   (vertex_count_ff),
      .texcoord_count (texcoord_count_ff),
      .normal_count   (normal_count_ff),
      .key            (chk_key),
      .status         (chk_status)
   );

   vtdi_table #(
      .SLOTS      (SLOTS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (probe_addr_ff),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data),
      .ready   (tbl_ready)
   );

   always_comb begin
      hash_fold = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
         hash_fold[i % SLOT_BITS] = hash_fold[i % SLOT_BITS] ^ chk_key[i];
      end
   end

   assign hash_sub   = {1'b0, hash_fold} - SLOTS_W;
   assign hash_slot  = ({1'b0, hash_fold} >= SLOTS_W) ? hash_sub[SLOT_BITS-1:0] : hash_fold;
   assign probe_next = (probe_addr_ff == LAST_SLOT) ? '0 : probe_addr_ff + 1'b1;

   assign busy   = ~tbl_ready | (state_ff != S_IDLE);
   assign accept = start & ~busy;

   assign ent_valid   = tbl_rd_data[ENTRY_BITS-1];
   assign ent_id      = tbl_rd_data[KEY_BITS +: ID_BITS];
   assign ent_key     = tbl_rd_data[KEY_BITS-1:0];
   assign new_id      = next_id_ff[ID_BITS-1:0];
   assign hit_wide    = {{OUT_INDEX_BITS{1'b0}}, ent_id};
   assign new_wide    = {{OUT_INDEX_BITS{1'b0}}, new_id};
   assign tbl_wr_data = {1'b1, new_id, key_ff};

   always_comb begin
      state_in      = state_ff;
      next_id_in    = next_id_ff;
      key_in        = key_ff;
      probe_addr_in = probe_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      tbl_wr_en     = 1'b0;
      tbl_rd_addr   = hash_slot;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (chk_status != ST_OK) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.out_index = '0;
                  rsp_in.is_new    = 1'b0;
                  rsp_in.status    = chk_status;
               end else begin
                  state_in      = S_PROBE;
                  key_in        = chk_key;
                  probe_addr_in = hash_slot;
               end
            end
         end
         S_PROBE: begin
            tbl_rd_addr = probe_next;
            if (ent_valid && ent_key == key_ff) begin
               state_in         = S_IDLE;
               rsp_strobe_in    = 1'b1;
               rsp_in.out_index = hit_wide[OUT_INDEX_BITS-1:0];
               rsp_in.is_new    = 1'b0;
               rsp_in.status    = ST_OK;
            end else if (!ent_valid) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               if (next_id_ff == FULL_ID) begin
                  rsp_in.out_index = '0;
                  rsp_in.is_new    = 1'b0;
                  rsp_in.status    = ST_FULL;
               end else begin
                  tbl_wr_en        = 1'b1;
                  next_id_in       = next_id_ff + 1'b1;
                  rsp_in.out_index = new_wide[OUT_INDEX_BITS-1:0];
                  rsp_in.is_new    = 1'b1;
                  rsp_in.status    = ST_OK;
               end
            end else begin
               probe_addr_in = probe_next;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         next_id_ff        <= '0;
         rsp_strobe_ff     <= 1'b0;
         vertex_count_ff   <= '0;
         texcoord_count_ff <= '0;
         normal_count_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         next_id_ff    <= next_id_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            case (csr_index)
               REG_VERTEX_COUNT:   vertex_count_ff   <= csr_wdata;
               REG_TEXCOORD_COUNT: texcoord_count_ff <= csr_wdata;
               REG_NORMAL_COUNT:   normal_count_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      probe_addr_ff <= probe_addr_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   `VTDI_ASSERT_NEXT(a_err_word_answers, clock, reset, accept && chk_status != ST_OK, rsp_strobe && rsp_word.status == $past(chk_status))
   `VTDI_ASSERT_IMPLIES(a_new_is_ok, clock, reset, rsp_strobe && rsp_word.is_new, rsp_word.status == ST_OK && next_id_ff == $past(next_id_ff) + 1'b1)
   `VTDI_ASSERT_IMPLIES(a_id_bound, clock, reset, 1'b1, next_id_ff <= FULL_ID)
   `VTDI_ASSERT_IMPLIES(a_strobe_source, clock, reset, rsp_strobe, $past(state_ff) == S_PROBE || $past(accept))

endmodule

// ===== tb/sv/corner_index_checker.sv =====
// Result checker for the vertex triple dedup indexer: tracks count writes, numbers each
// accepted corner in its own triple table and compares every answer with the oldest one.
// Depends on vtdi_pkg.
module corner_index_checker
   import vtdi_pkg::*;
#(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  req_type                   req_word,
   input  logic                      rsp_strobe,
   input  rsp_type                   rsp_word,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        outstanding,
   output int                        checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [FIELD_BITS-1:0]     vertex_limit;
   logic [FIELD_BITS-1:0]     texcoord_limit;
   logic [FIELD_BITS-1:0]     normal_limit;
   logic [OUT_INDEX_BITS-1:0] id_of_triple [logic [3*FIELD_BITS-1:0]];
   int                        next_free;
   rsp_type                   pending_answers[$];
   rsp_type                   want;

   function automatic rsp_type number_corner(req_type c);
      rsp_type                 r;
      logic [3*FIELD_BITS-1:0] key;
      r = '0;
      r.status = ST_OK;
      key = c;
      if (c.pos_index == 0 || c.pos_index > vertex_limit) begin
         r.status = ST_VERTEX;
      end else if (c.tex_index > texcoord_limit) begin
         r.status = ST_TEX;
      end else if (c.norm_index > normal_limit) begin
         r.status = ST_NORM;
      end else if (id_of_triple.exists(key)) begin
         r.out_index = id_of_triple[key];
      end else if (next_free >= TABLE_SLOTS) begin
         r.status = ST_FULL;
      end else begin
         id_of_triple[key] = next_free[OUT_INDEX_BITS-1:0];
         r.out_index = next_free[OUT_INDEX_BITS-1:0];
         r.is_new = 1'b1;
         next_free++;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         vertex_limit = '0;
         texcoord_limit = '0;
         normal_limit = '0;
         id_of_triple.delete();
         next_free = 0;
         pending_answers.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_VERTEX_COUNT: vertex_limit = csr_wdata;
               REG_TEXCOORD_COUNT: texcoord_limit = csr_wdata;
               REG_NORMAL_COUNT: normal_limit = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            checked++;
            if (pending_answers.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected answer: index %0d new %0b status %0d",
                     rsp_word.out_index, rsp_word.is_new, rsp_word.status);
               end
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_word.out_index !== want.out_index || rsp_word.is_new !== want.is_new ||
                   rsp_word.status !== want.status) begin
                  if (fail_count < 10) begin
                     $display("answer %0d: expected index %0d new %0b status %0d, got %0d %0b %0d",
                        checked, want.out_index, want.is_new, want.status,
                        rsp_word.out_index, rsp_word.is_new, rsp_word.status);
                  end
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            pending_answers.push_back(number_corner(req_word));
         end
      end
      outstanding = pending_answers.size();
   end

endmodule

// ===== tb/sv/tb_vertex_triple_dedup_indexer_top.sv =====
// Testbench top for the vertex triple dedup indexer: directed corners, random phases over
// several count settings and a run of distinct triples at full counts; verdict from the checker.
// Depends on vtdi_pkg, corner_index_checker and vertex_triple_dedup_indexer_top.
module tb_vertex_triple_dedup_indexer_top
   import vtdi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;
   localparam int TABLE_SLOTS    = 1024;
   localparam int PHASE_ITEMS    = 80;
   localparam int RANDOM_PHASES  = 5;
   localparam int FILL_TRIPLES   = 120;
   localparam int SETTLE_CYCLES  = TABLE_SLOTS + 16;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_word;
   logic                      rsp_strobe;
   rsp_type                   rsp_word;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int                        fail_count;
   int                        outstanding;
   int                        checked;
   int                        items_sent;
   int                        settings_used;
   int                        burst_left;

   vertex_triple_dedup_indexer_top #(.TABLE_ENTRIES(TABLE_SLOTS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   corner_index_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .outstanding(outstanding), .checked(checked)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic req_type corner(int p, int t, int n);
      req_type c;
      c.pos_index = p[FIELD_BITS-1:0];
      c.tex_index = t[FIELD_BITS-1:0];
      c.norm_index = n[FIELD_BITS-1:0];
      return c;
   endfunction

   function automatic req_type noise_word();
      return corner($urandom, $urandom, $urandom);
   endfunction

   function automatic int pick_within(int lo, int hi);
      int span;
      span = hi - lo;
      if ($urandom_range(0, 1)) return lo + $urandom_range(0, span < 5 ? span : 5);
      return hi - $urandom_range(0, span < 2 ? span : 2);
   endfunction

   function automatic int pick_beyond(int count);
      if (count >= 65535) return 65535;
      if ($urandom_range(0, 1)) return count + 1;
      return $urandom_range(count + 1, 65535);
   endfunction

   function automatic req_type make_corner(int vc, int tc, int nc);
      int kind;
      int p;
      int t;
      int n;
      kind = $urandom_range(0, 99);
      p = vc > 0 ? pick_within(1, vc) : 1;
      t = pick_within(0, tc);
      n = pick_within(0, nc);
      if (kind >= 88) return noise_word();
      if (kind >= 70) begin
         case (kind % 4)
            0: p = 0;
            1: p = pick_beyond(vc);
            2: t = pick_beyond(tc);
            default: n = pick_beyond(nc);
         endcase
      end
      return corner(p, t, n);
   endfunction

   task automatic send_corner(input req_type c);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 13);
         if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(8, 30);
      end
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         req_word <= noise_word();
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_word <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      req_word <= noise_word();
      while (outstanding != 0 || busy) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_counts(input int vc, input int tc, input int nc);
      drain_results();
      write_reg(REG_VERTEX_COUNT, vc);
      write_reg(REG_TEXCOORD_COUNT, tc);
      write_reg(REG_NORMAL_COUNT, nc);
      write_reg(REG_SPARE, $urandom);
      settings_used++;
   endtask

   initial begin
      #(100_000_000);
      $display("tb_vertex_triple_dedup_indexer_top: FAIL");
      $finish;
   end

   initial begin
      int vc;
      int tc;
      int nc;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      items_sent = 0;
      settings_used = 1;
      burst_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (busy) @(negedge clock);

      send_corner(corner(1, 0, 0));
      set_counts(10, 5, 3);
      send_corner(corner(0, 0, 0));
      send_corner(corner(1, 0, 0));
      send_corner(corner(1, 0, 0));
      send_corner(corner(10, 5, 3));
      send_corner(corner(11, 0, 0));
      send_corner(corner(1, 6, 0));
      send_corner(corner(1, 0, 4));
      send_corner(corner(11, 6, 4));
      send_corner(corner(1, 6, 4));
      send_corner(corner(65535, 65535, 65535));
      send_corner(corner(0, 65535, 65535));
      send_corner(corner(10, 0, 3));
      send_corner(corner(1, 5, 0));
      set_counts(65535, 65535, 65535);
      send_corner(corner(65535, 65535, 65535));
      send_corner(corner(1, 0, 0));
      send_corner(corner(65535, 0, 65535));
      send_corner(corner(0, 0, 0));
      send_corner(corner(10, 5, 3));
      set_counts(65535, 0, 0);
      send_corner(corner(65535, 1, 0));
      send_corner(corner(65535, 0, 1));
      send_corner(corner(65535, 0, 0));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               vc = $urandom_range(1, 8);
               tc = $urandom_range(0, 4);
               nc = $urandom_range(0, 4);
            end
            1: begin
               vc = 65535;
               tc = 0;
               nc = 0;
            end
            2: begin
               vc = 65535;
               tc = 65535;
               nc = 65535;
            end
            3: begin
               vc = $urandom_range(0, 65535);
               tc = $urandom_range(0, 65535);
               nc = $urandom_range(0, 65535);
            end
            default: begin
               vc = 1;
               tc = 1;
               nc = 1;
            end
         endcase
         set_counts(vc, tc, nc);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 49) == 0) drain_results();
            send_corner(make_corner(vc, tc, nc));
         end
      end

      set_counts(65535, 65535, 65535);
      for (int i = 0; i < FILL_TRIPLES; i++) begin
         send_corner(corner(30001 + i, 65535 - i, i + 1));
      end
      for (int i = 0; i < 4; i++) begin
         send_corner(corner(30001 + i, 65535 - i, i + 1));
         send_corner(corner($urandom_range(1, 65535), $urandom, $urandom));
      end
      send_corner(corner(1, 0, 0));

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("sent %0d corners over %0d count settings, %0d answers checked",
         items_sent, settings_used, checked);
      $display("stored a run of %0d distinct triples at full counts, then repeated some",
         FILL_TRIPLES);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_vertex_triple_dedup_indexer_top: PASS");
      end else begin
         $display("tb_vertex_triple_dedup_indexer_top: FAIL");
      end
      $finish;
   end

endmodule
